/* rtl/psvs_pkg.sv */
// ----------------------------------------------------------------------------
// psvs_pkg - shared definitions for the sine voice synthesiser
// Command codes, control structs, defaults and elaboration-time table builders.
// ----------------------------------------------------------------------------
package psvs_pkg;

   localparam int VOICES_DEFAULT          = 8;
   localparam int PHASE_BITS_DEFAULT      = 24;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam int NOTE_W     = 7;
   localparam int NOTE_COUNT = 128;
   localparam int GAIN_W     = 16;
   localparam int SAMPLE_W   = 16;
   localparam int ROM_W      = 15;
   localparam int RESET_NOTE = 45;

   localparam longint unsigned COEF_A = 51472;
   localparam longint unsigned COEF_B = 21024;
   localparam longint unsigned COEF_C = 2320;

   typedef logic [1:0] command_type;
   localparam command_type CMD_TICK     = 2'd0;
   localparam command_type CMD_NOTE_ON  = 2'd1;
   localparam command_type CMD_NOTE_OFF = 2'd2;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } mix_ctrl_type;

   // phase increment of note n, top octave entry shifted down by octave with rounding
   function automatic logic [31:0] note_increment(int unsigned n, int unsigned phase_bits);
      longint unsigned v;
      int unsigned     k;
      int unsigned     r;
      int unsigned     sh;
      k = (n % 128) / 12;
      r = (n % 128) % 12;
      case (r)
         0:       v = 64'd815363807;
         1:       v = 64'd863847862;
         2:       v = 64'd915214929;
         3:       v = 64'd969636441;
         4:       v = 64'd1027294024;
         5:       v = 64'd1088380105;
         6:       v = 64'd1153098554;
         7:       v = 64'd1221665362;
         8:       v = 64'd1294309365;
         9:       v = 64'd1371273005;
         10:      v = 64'd1452813141;
         default: v = 64'd1539201906;
      endcase
      sh = (10 - k) + (32 - phase_bits);
      if (sh > 0) begin
         v = (v + (64'd1 << (sh - 1))) >> sh;
      end
      return 32'(v & ((64'd1 << phase_bits) - 64'd1));
   endfunction

   // floor(32768 * (vel/127)^(1/4)) by binary search
   function automatic logic [GAIN_W-1:0] velocity_gain(int unsigned vel);
      longint unsigned v;
      longint unsigned num;
      longint unsigned x;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned sq;
      v   = longint'(vel % 128);
      num = v << 53;
      x   = ((num / 127) << 7) + (((num % 127) << 7) / 127);
      lo  = 0;
      hi  = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         sq  = mid * mid;
         if (sq * sq <= x) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return GAIN_W'(lo);
   endfunction

   // quarter wave polynomial, Q15
   function automatic logic [ROM_W-1:0] quarter_sine(int unsigned q, int unsigned table_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned u;
      longint unsigned w;
      longint unsigned s;
      x  = longint'(q) << (15 - (table_bits - 2));
      x2 = (x * x + 16384) >> 15;
      u  = COEF_B - ((COEF_C * x2 + 16384) >> 15);
      w  = COEF_A - ((u * x2 + 16384) >> 15);
      s  = (x * w + 16384) >> 15;
      if (s > 32767) begin
         s = 32767;
      end
      return ROM_W'(s);
   endfunction

endpackage

/* rtl/psvs_req_if.sv */
// ----------------------------------------------------------------------------
// psvs_req_if - request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface psvs_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           command;
   logic [6:0]           note;
   logic [6:0]           velocity;
   logic signed [15:0]   left_in;
   logic signed [15:0]   right_in;

   modport source (output valid, command, note, velocity, left_in, right_in, input ready);
   modport sink (input valid, command, note, velocity, left_in, right_in, output ready);
endinterface

/* rtl/psvs_rsp_if.sv */
// ----------------------------------------------------------------------------
// psvs_rsp_if - response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface psvs_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   left_out;
   logic signed [15:0]   right_out;
   logic [2:0]           assigned_voice;
   logic [3:0]           released_count;

   modport source (output valid, left_out, right_out, assigned_voice, released_count,
                   input ready);
   modport sink (input valid, left_out, right_out, assigned_voice, released_count,
                 output ready);
endinterface

/* rtl/psvs_voice_cell.sv */
// ----------------------------------------------------------------------------
// psvs_voice_cell - one voice slot of the rotating ring
// Holds phase, increment, note and gain; shifts from its neighbour or loads.
// ----------------------------------------------------------------------------
module psvs_voice_cell #(
   parameter int                    PHASE_BITS = psvs_pkg::PHASE_BITS_DEFAULT,
   parameter logic [PHASE_BITS-1:0] RESET_INC  = '0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  psvs_pkg::cell_ctrl_type         ctrl,
   input  logic [PHASE_BITS-1:0]           chain_phase,
   input  logic [PHASE_BITS-1:0]           chain_inc,
   input  logic [psvs_pkg::NOTE_W-1:0]     chain_note,
   input  logic [psvs_pkg::GAIN_W-1:0]     chain_gain,
   input  logic [PHASE_BITS-1:0]           load_inc,
   input  logic [psvs_pkg::NOTE_W-1:0]     load_note,
   input  logic [psvs_pkg::GAIN_W-1:0]     load_gain,
   output logic [PHASE_BITS-1:0]           phase,
   output logic [PHASE_BITS-1:0]           inc,
   output logic [psvs_pkg::NOTE_W-1:0]     note,
   output logic [psvs_pkg::GAIN_W-1:0]     gain
);

   logic [PHASE_BITS-1:0]       phase_ff;
   logic [PHASE_BITS-1:0]       inc_ff;
   logic [psvs_pkg::NOTE_W-1:0] note_ff;
   logic [psvs_pkg::GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         inc_ff   <= RESET_INC;
         note_ff  <= '0;
         gain_ff  <= '0;
      end else if (ctrl.shift) begin
         phase_ff <= chain_phase;
         inc_ff   <= chain_inc;
         note_ff  <= chain_note;
         gain_ff  <= chain_gain;
      end else if (ctrl.load) begin
         inc_ff   <= load_inc;
         note_ff  <= load_note;
         gain_ff  <= load_gain;
      end
   end

   assign phase = phase_ff;
   assign inc   = inc_ff;
   assign note  = note_ff;
   assign gain  = gain_ff;

endmodule

/* rtl/psvs_mix_unit.sv */
// ----------------------------------------------------------------------------
// psvs_mix_unit - sine lookup, gain multiply and mix accumulator
// Three-stage pipeline fed by the head cell of the ring, one voice a cycle.
// ----------------------------------------------------------------------------
module psvs_mix_unit #(
   parameter int PHASE_BITS      = psvs_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = psvs_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int ACC_W           = 21
) (
   input  logic                        clock,
   input  logic                        reset,
   input  psvs_pkg::mix_ctrl_type      ctrl,
   input  logic [PHASE_BITS-1:0]       phase,
   input  logic [psvs_pkg::GAIN_W-1:0] gain,
   output logic                        busy,
   output logic signed [ACC_W-1:0]     acc
);

   localparam int QW   = SINE_TABLE_BITS - 2;
   localparam int QLEN = 1 << QW;
   localparam int RW   = psvs_pkg::ROM_W;
   localparam int GW   = psvs_pkg::GAIN_W;

   logic [RW-1:0] sine_rom [QLEN+1];

   for (genvar g = 0; g <= QLEN; g++) begin : g_rom
      assign sine_rom[g] = psvs_pkg::quarter_sine(g, SINE_TABLE_BITS);
   end

   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]                 quad;
   logic [QW-1:0]              qpos;
   logic [QW:0]                rom_addr;

   assign idx      = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign quad     = idx[SINE_TABLE_BITS-1 -: 2];
   assign qpos     = idx[QW-1:0];
   assign rom_addr = quad[0] ? ((QW+1)'(QLEN) - {1'b0, qpos}) : {1'b0, qpos};

   logic [RW-1:0]           rom_ff;
   logic                    neg_ff;
   logic [GW-1:0]           gain_ff;
   logic                    valid_a_ff;
   logic signed [32:0]      prod_ff;
   logic                    valid_b_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic signed [RW:0]      sine_val;
   logic signed [32:0]      prod_in;
   logic signed [32:0]      rnd_sh;
   logic signed [16:0]      term;
   logic signed [ACC_W-1:0] acc_in;

   assign sine_val = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});
   assign prod_in  = sine_val * $signed({1'b0, gain_ff});
   assign rnd_sh   = (prod_ff + 33'sd16384) >>> 15;
   assign term     = rnd_sh[16:0];

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (valid_b_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      rom_ff  <= sine_rom[rom_addr];
      neg_ff  <= quad[1];
      gain_ff <= gain;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= ctrl.sample;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign busy = valid_a_ff || valid_b_ff;
   assign acc  = acc_ff;

endmodule

/* rtl/polyphonic_sine_voice_synth_core.sv */
// Tick: rotate, drain the mix, finish; requests are accepted only back in idle.
// Note off: rotate, finish; note on: assign, finish; unused command: finish only.
// The ring of voice cells rotates once per tick or note off, each voice passing
// the single mix unit at cell zero; finish waits for a free response slot.
// Synchronous reset: voices silent and free, increments at note 45, pointer zero.
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_synth_core - polyphonic sine voice synthesiser
// Ring of voice cells with round-robin note allocation and a shared mixer.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_synth_core #(
   parameter int VOICES          = psvs_pkg::VOICES_DEFAULT,
   parameter int PHASE_BITS      = psvs_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = psvs_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   psvs_req_if.sink      req_ch,
   psvs_rsp_if.source    rsp_ch
);

   localparam int SLOT_W = $clog2(VOICES);
   localparam int ACC_W  = 18 + SLOT_W;
   localparam int SUM_W  = ACC_W + 1;
   localparam int NW     = psvs_pkg::NOTE_W;
   localparam int GW     = psvs_pkg::GAIN_W;
   localparam int NC     = psvs_pkg::NOTE_COUNT;
   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(VOICES - 1);
   localparam logic [PHASE_BITS-1:0] RESET_INC =
      PHASE_BITS'(psvs_pkg::note_increment(psvs_pkg::RESET_NOTE, PHASE_BITS));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DRAIN,
      ST_ASSIGN,
      ST_FINISH
   } state_type;

   // note tables
   logic [GW-1:0]         gain_rom [NC];
   logic [PHASE_BITS-1:0] inc_rom  [NC];

   for (genvar g = 0; g < NC; g++) begin : g_tab
      assign gain_rom[g] = psvs_pkg::velocity_gain(g);
      assign inc_rom[g]  = PHASE_BITS'(psvs_pkg::note_increment(g, PHASE_BITS));
   end

   // registers
   state_type             state_ff, state_in;
   psvs_pkg::command_type cmd_ff, cmd_in;
   logic [NW-1:0]         note_ff, note_in;
   logic [NW-1:0]         vel_ff, vel_in;
   logic signed [15:0]    smp_left_ff, smp_left_in;
   logic signed [15:0]    smp_right_ff, smp_right_in;
   logic [SLOT_W-1:0]     rot_ff, rot_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [2:0]            voice_ff, voice_in;
   logic [SLOT_W-1:0]     next_slot_ff, next_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]    out_left_ff, out_left_in;
   logic signed [15:0]    out_right_ff, out_right_in;
   logic [2:0]            out_voice_ff, out_voice_in;
   logic [3:0]            out_count_ff, out_count_in;

   // ring
   logic [PHASE_BITS-1:0]   cell_phase [VOICES];
   logic [PHASE_BITS-1:0]   cell_inc   [VOICES];
   logic [NW-1:0]           cell_note  [VOICES];
   logic [GW-1:0]           cell_gain  [VOICES];
   logic [PHASE_BITS-1:0]   nxt_phase  [VOICES];
   logic [PHASE_BITS-1:0]   nxt_inc    [VOICES];
   logic [NW-1:0]           nxt_note   [VOICES];
   logic [GW-1:0]           nxt_gain   [VOICES];
   psvs_pkg::cell_ctrl_type cell_ctrl  [VOICES];

   logic [PHASE_BITS-1:0]   ret_phase;
   logic [PHASE_BITS-1:0]   ret_inc;
   logic [NW-1:0]           ret_note;
   logic [GW-1:0]           ret_gain;
   logic                    head_hit;

   logic [SLOT_W-1:0]       assign_slot;
   logic [SLOT_W-1:0]       slot_after;

   psvs_pkg::mix_ctrl_type  mix_ctrl;
   logic                    mix_busy;
   logic signed [ACC_W-1:0] mix_acc;
   logic signed [SUM_W-1:0] sum_left;
   logic signed [SUM_W-1:0] sum_right;
   logic                    accept;

   for (genvar g = 0; g < VOICES; g++) begin : g_cell
      if (g == VOICES - 1) begin : g_tail
         assign nxt_phase[g] = ret_phase;
         assign nxt_inc[g]   = ret_inc;
         assign nxt_note[g]  = ret_note;
         assign nxt_gain[g]  = ret_gain;
      end else begin : g_body
         assign nxt_phase[g] = cell_phase[g+1];
         assign nxt_inc[g]   = cell_inc[g+1];
         assign nxt_note[g]  = cell_note[g+1];
         assign nxt_gain[g]  = cell_gain[g+1];
      end

      psvs_voice_cell #(
         .PHASE_BITS (PHASE_BITS),
         .RESET_INC  (RESET_INC)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[g]),
         .chain_phase (nxt_phase[g]),
         .chain_inc   (nxt_inc[g]),
         .chain_note  (nxt_note[g]),
         .chain_gain  (nxt_gain[g]),
         .load_inc    (inc_rom[note_ff]),
         .load_note   (note_ff),
         .load_gain   (gain_rom[vel_ff]),
         .phase       (cell_phase[g]),
         .inc         (cell_inc[g]),
         .note        (cell_note[g]),
         .gain        (cell_gain[g])
      );
   end

   psvs_mix_unit #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .ACC_W           (ACC_W)
   ) u_mix (
      .clock (clock),
      .reset (reset),
      .ctrl  (mix_ctrl),
      .phase (cell_phase[0]),
      .gain  (cell_gain[0]),
      .busy  (mix_busy),
      .acc   (mix_acc)
   );

   // head of ring: advance on tick, clear on matching note off
   assign head_hit  = (cmd_ff == psvs_pkg::CMD_NOTE_OFF) && (cell_note[0] == note_ff);
   assign ret_phase = (cmd_ff == psvs_pkg::CMD_TICK) ? (cell_phase[0] + cell_inc[0])
                                                     : cell_phase[0];
   assign ret_inc   = head_hit ? '0 : cell_inc[0];
   assign ret_note  = head_hit ? '0 : cell_note[0];
   assign ret_gain  = head_hit ? '0 : cell_gain[0];

   always_comb begin
      assign_slot = next_slot_ff;
      if (cell_note[next_slot_ff] != '0) begin
         assign_slot = (next_slot_ff == LAST_SLOT) ? '0 : next_slot_ff + 1'b1;
      end
   end
   assign slot_after = (assign_slot == LAST_SLOT) ? '0 : assign_slot + 1'b1;

   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         cell_ctrl[i].shift = (state_ff == ST_ROTATE);
         cell_ctrl[i].load  = (state_ff == ST_ASSIGN) && (assign_slot == SLOT_W'(i));
      end
   end

   assign accept          = req_ch.valid && req_ch.ready;
   assign mix_ctrl.clear  = accept;
   assign mix_ctrl.sample = (state_ff == ST_ROTATE) && (cmd_ff == psvs_pkg::CMD_TICK);

   assign sum_left  = SUM_W'(smp_left_ff) + SUM_W'(mix_acc);
   assign sum_right = SUM_W'(smp_right_ff) + SUM_W'(mix_acc);

   function automatic logic signed [15:0] sat16(logic signed [SUM_W-1:0] v);
      if (v > $signed(SUM_W'(32767))) begin
         return 16'sh7FFF;
      end else if (v < $signed(SUM_W'(-32768))) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      smp_left_in  = smp_left_ff;
      smp_right_in = smp_right_ff;
      rot_in       = rot_ff;
      cnt_in       = cnt_ff;
      voice_in     = voice_ff;
      next_slot_in = next_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_voice_in = out_voice_ff;
      out_count_in = out_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in       = req_ch.command;
               note_in      = req_ch.note;
               vel_in       = req_ch.velocity;
               smp_left_in  = req_ch.left_in;
               smp_right_in = req_ch.right_in;
               rot_in       = '0;
               cnt_in       = '0;
               voice_in     = '0;
               case (req_ch.command)
                  psvs_pkg::CMD_TICK,
                  psvs_pkg::CMD_NOTE_OFF: state_in = ST_ROTATE;
                  psvs_pkg::CMD_NOTE_ON:  state_in = ST_ASSIGN;
                  default:                state_in = ST_FINISH;
               endcase
            end
         end
         ST_ROTATE: begin
            rot_in = rot_ff + 1'b1;
            if (head_hit && (cnt_ff != 4'hF)) begin
               cnt_in = cnt_ff + 4'd1;
            end
            if (rot_ff == LAST_SLOT) begin
               state_in = (cmd_ff == psvs_pkg::CMD_TICK) ? ST_DRAIN : ST_FINISH;
            end
         end
         ST_DRAIN: begin
            if (!mix_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_ASSIGN: begin
            next_slot_in = slot_after;
            voice_in     = 3'(assign_slot);
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_left_in  = '0;
               out_right_in = '0;
               out_voice_in = '0;
               out_count_in = '0;
               case (cmd_ff)
                  psvs_pkg::CMD_TICK: begin
                     out_left_in  = sat16(sum_left);
                     out_right_in = sat16(sum_right);
                  end
                  psvs_pkg::CMD_NOTE_ON:  out_voice_in = voice_ff;
                  psvs_pkg::CMD_NOTE_OFF: out_count_in = cnt_ff;
                  default: ;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      note_ff      <= note_in;
      vel_ff       <= vel_in;
      smp_left_ff  <= smp_left_in;
      smp_right_ff <= smp_right_in;
      voice_ff     <= voice_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_voice_ff <= out_voice_in;
      out_count_ff <= out_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_ff       <= '0;
         cnt_ff       <= '0;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         cnt_ff       <= cnt_in;
         next_slot_ff <= next_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.left_out       = out_left_ff;
   assign rsp_ch.right_out      = out_right_ff;
   assign rsp_ch.assigned_voice = out_voice_ff;
   assign rsp_ch.released_count = out_count_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("item accepted while previous item in progress");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   a_slot_written: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ASSIGN |=> cell_note[$past(assign_slot)] == $past(note_ff))
      else $error("note on did not reach the chosen slot");

   a_mix_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mix_busy)
      else $error("mix pipeline active while idle");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= LAST_SLOT)
      else $error("allocation pointer beyond last voice");

endmodule

/* bench/tb_polyphonic_sine_voice_synth_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphonic_sine_voice_synth_core - bench for the sine voice synthesiser
// Drives ticks, note ons, note offs and unused commands through the request channel
// with random gaps and one long result hold-off. A scoreboard keeps its own voice
// state, predicts every result and checks the response channel item by item.
// ----------------------------------------------------------------------------
module tb_polyphonic_sine_voice_synth_core;

   localparam int NV = psvs_pkg::VOICES_DEFAULT;
   localparam int PB = psvs_pkg::PHASE_BITS_DEFAULT;
   localparam int TB = psvs_pkg::SINE_TABLE_BITS_DEFAULT;
   localparam int QL = 1 << (TB - 2);
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 3 * (NV + 5);
   localparam int SQUEEZE_CYCLES = 300;
   localparam int RANDOM_ITEMS = 500;
   localparam psvs_pkg::command_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [2:0]         assigned_voice;
      logic [3:0]         released_count;
   } synth_result_type;

   class voice_mix_tracker;
      logic [PB-1:0]     phase_acc [NV];
      logic [PB-1:0]     phase_step [NV];
      logic [6:0]        held_note [NV];
      logic [6:0]        held_vel [NV];
      int                rr_slot;
      logic [PB-1:0]     tune_tbl [128];
      longint            gain_tbl [128];
      longint            quarter_tbl [QL+1];
      synth_result_type  pending [$];
      int                mismatches;
      int                checked;
      int                n_tick;
      int                n_on;
      int                n_off;
      int                n_other;

      function new();
         longint unsigned top_oct [12];
         longint unsigned v;
         longint unsigned num;
         longint unsigned x;
         longint unsigned x2;
         longint unsigned u;
         longint unsigned w;
         longint unsigned lo;
         longint unsigned hi;
         longint unsigned mid;
         int              sh;
         top_oct = '{815363807, 863847862, 915214929, 969636441, 1027294024, 1088380105,
                     1153098554, 1221665362, 1294309365, 1371273005, 1452813141, 1539201906};
         for (int n = 0; n < 128; n++) begin
            sh = (10 - n / 12) + (32 - PB);
            v  = top_oct[n % 12];
            if (sh > 0) v = (v + (64'd1 << (sh - 1))) >> sh;
            tune_tbl[n] = PB'(v);
         end
         for (int g = 0; g < 128; g++) begin
            num = longint'(g) << 53;
            x   = ((num / 127) << 7) + (((num % 127) << 7) / 127);
            lo  = 0;
            hi  = 32768;
            while (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               if (mid * mid * mid * mid <= x) lo = mid;
               else hi = mid - 1;
            end
            gain_tbl[g] = longint'(lo);
         end
         for (int q = 0; q <= QL; q++) begin
            x  = longint'(q) << (15 - (TB - 2));
            x2 = (x * x + 16384) >> 15;
            u  = psvs_pkg::COEF_B - ((psvs_pkg::COEF_C * x2 + 16384) >> 15);
            w  = psvs_pkg::COEF_A - ((u * x2 + 16384) >> 15);
            v  = (x * w + 16384) >> 15;
            if (v > 32767) v = 32767;
            quarter_tbl[q] = longint'(v);
         end
         for (int i = 0; i < NV; i++) begin
            phase_acc[i]  = '0;
            phase_step[i] = tune_tbl[psvs_pkg::RESET_NOTE];
            held_note[i]  = '0;
            held_vel[i]   = '0;
         end
         rr_slot    = 0;
         mismatches = 0;
         checked    = 0;
         n_tick     = 0;
         n_on       = 0;
         n_off      = 0;
         n_other    = 0;
      endfunction

      function longint sine_at(logic [PB-1:0] ph);
         logic [TB-1:0] idx;
         int            q;
         longint        s;
         idx = ph[PB-1 -: TB];
         q   = int'(idx[TB-3:0]);
         if (idx[TB-2]) q = QL - q;
         s = quarter_tbl[q];
         return idx[TB-1] ? -s : s;
      endfunction

      function logic signed [15:0] clip16(longint val);
         if (val > 32767) return 16'sh7FFF;
         if (val < -32768) return 16'sh8000;
         return 16'(val);
      endfunction

      function void note_item(psvs_pkg::command_type cmd, logic [6:0] nt, logic [6:0] vel,
                              logic signed [15:0] lin, logic signed [15:0] rin);
         synth_result_type res;
         longint           mix;
         longint           prod;
         int               slot;
         int               cnt;
         res = '0;
         case (cmd)
            psvs_pkg::CMD_TICK: begin
               mix = 0;
               for (int i = 0; i < NV; i++) begin
                  prod = sine_at(phase_acc[i]) * gain_tbl[held_vel[i]];
                  mix += (prod + 16384) >>> 15;
               end
               res.left_out  = clip16(longint'(lin) + mix);
               res.right_out = clip16(longint'(rin) + mix);
               for (int i = 0; i < NV; i++) phase_acc[i] = phase_acc[i] + phase_step[i];
               n_tick++;
            end
            psvs_pkg::CMD_NOTE_ON: begin
               slot = rr_slot % NV;
               if (held_note[slot] != 0) slot = (slot + 1) % NV;
               held_note[slot]  = nt;
               held_vel[slot]   = vel;
               phase_step[slot] = tune_tbl[nt];
               rr_slot = (slot + 1) % NV;
               res.assigned_voice = 3'(slot);
               n_on++;
            end
            psvs_pkg::CMD_NOTE_OFF: begin
               cnt = 0;
               for (int i = 0; i < NV; i++) begin
                  if (held_note[i] == nt) begin
                     held_note[i]  = '0;
                     held_vel[i]   = '0;
                     phase_step[i] = '0;
                     cnt++;
                  end
               end
               res.released_count = 4'((cnt > 15) ? 15 : cnt);
               n_off++;
            end
            default: n_other++;
         endcase
         pending.push_back(res);
      endfunction

      function void check_result(synth_result_type got);
         synth_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected: left %0d right %0d voice %0d released %0d",
                     $time, got.left_out, got.right_out, got.assigned_voice,
                     got.released_count);
            mismatches++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.left_out !== exp.left_out || got.right_out !== exp.right_out ||
             got.assigned_voice !== exp.assigned_voice ||
             got.released_count !== exp.released_count) begin
            $display("%0t: mismatch expected left %0d right %0d voice %0d released %0d",
                     $time, exp.left_out, exp.right_out, exp.assigned_voice,
                     exp.released_count);
            $display("%0t:            actual left %0d right %0d voice %0d released %0d",
                     $time, got.left_out, got.right_out, got.assigned_voice,
                     got.released_count);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   calm [2];
   bit   squeeze_rsp;
   int   quiet;

   voice_mix_tracker tracker;

   psvs_req_if req_ch ();
   psvs_rsp_if rsp_ch ();

   polyphonic_sine_voice_synth_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // side 0 is the sender, side 1 the receiver
   function automatic int draw_wait(int side);
      if (calm[side] > 0) begin
         calm[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm[side] = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] pick_velocity();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd127;
         default: return 7'($urandom);
      endcase
   endfunction

   task automatic send_item(psvs_pkg::command_type cmd, logic [6:0] nt, logic [6:0] vel,
                            logic signed [15:0] lin, logic signed [15:0] rin);
      int gap;
      gap = draw_wait(0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.note     <= nt;
      req_ch.velocity <= vel;
      req_ch.left_in  <= lin;
      req_ch.right_in <= rin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result('{rsp_ch.left_out, rsp_ch.right_out,
                                   rsp_ch.assigned_voice, rsp_ch.released_count});
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_item(req_ch.command, req_ch.note, req_ch.velocity,
                              req_ch.left_in, req_ch.right_in);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d results outstanding",
                  quiet, tracker.pending.size());
         $display("** polyphonic_sine_voice_synth_core: FAILED **");
         $finish;
      end
   end

   // result side: random hold-offs and one long squeeze
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_wait(1);
         if (squeeze_rsp) begin
            gap = SQUEEZE_CYCLES;
            squeeze_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      int          issued;
      int          pick;
      int          j;
      bit          squeezed;
      logic [6:0]  nt;
      logic [6:0]  sounding [$];
      tracker     = new();
      calm        = '{0, 0};
      squeeze_rsp = 1'b0;
      squeezed    = 1'b0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.command  <= psvs_pkg::CMD_TICK;
      req_ch.note     <= '0;
      req_ch.velocity <= '0;
      req_ch.left_in  <= '0;
      req_ch.right_in <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, field extremes, slot wrap and overwrite, note zero
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_TICK, 7'd127, 7'd127, 16'sh7FFF, 16'sh8000);
      send_item(CMD_UNUSED, 7'd127, 7'd127, 16'sh7FFF, 16'sh8000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd69, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd127, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd0, 7'd0, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd1, 7'd1, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd60, 7'd100, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd60, 7'd90, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd12, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd24, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd96, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_ON, 7'd120, 7'd64, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sh7FFF, 16'sh7FFF);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sh8000, 16'sh8000);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, -16'sd1, 16'sd1);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sd100, -16'sd100);
      send_item(psvs_pkg::CMD_NOTE_OFF, 7'd60, 7'd0, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_OFF, 7'd0, 7'd0, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_NOTE_OFF, 7'd5, 7'd127, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sh4000, -16'sh4000);
      send_item(psvs_pkg::CMD_NOTE_OFF, 7'd127, 7'd0, 16'sh0000, 16'sh0000);
      send_item(psvs_pkg::CMD_TICK, 7'd0, 7'd0, 16'sh7FFF, 16'sh8000);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_item(CMD_UNUSED, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 50) begin
            send_item(psvs_pkg::CMD_TICK, 7'($urandom), 7'($urandom), pick_sample(),
                      pick_sample());
            issued++;
         end else if (pick < 78) begin
            nt = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            send_item(psvs_pkg::CMD_NOTE_ON, nt, pick_velocity(), 16'($urandom),
                      16'($urandom));
            if (nt != 0) sounding.push_back(nt);
            if (sounding.size() > 16) sounding.delete(0);
            issued++;
         end else begin
            if (sounding.size() > 0 && $urandom_range(0, 4) != 0) begin
               nt = sounding[$urandom_range(0, sounding.size() - 1)];
            end else begin
               nt = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom);
            end
            for (j = sounding.size() - 1; j >= 0; j--) begin
               if (sounding[j] == nt) sounding.delete(j);
            end
            send_item(psvs_pkg::CMD_NOTE_OFF, nt, 7'($urandom), 16'($urandom),
                      16'($urandom));
            issued++;
         end
         if (issued == 120 && !squeezed) begin
            squeezed    = 1'b1;
            squeeze_rsp = 1'b1;
            calm[0]     = 60;
         end
      end
      req_ch.valid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d ticks, %0d note ons, %0d note offs, %0d unused commands.",
               tracker.n_tick, tracker.n_on, tracker.n_off, tracker.n_other);
      $display("%0d results checked against prediction, %0d mismatches.",
               tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
         $display("** polyphonic_sine_voice_synth_core: PASSED **");
      end else begin
         $display("** polyphonic_sine_voice_synth_core: FAILED **");
      end
      $finish;
   end

endmodule
